/* rtl/core/spdif_fmt_pkg.sv */
// Shared types, constants and word-packing function for the S/PDIF subframe formatter.
`timescale 1ns / 1ps

package spdif_fmt_pkg;

  // Channel-status register width and reset value (byte zero lowest).
  localparam int unsigned CS_WIDTH = 40;
  localparam logic [CS_WIDTH-1:0] CS_RESET = 40'h0B_0000_0004;

  // Default number of frames that carry a status bit.
  localparam int unsigned STATUS_BITS_DEFAULT = 40;

  // Block structure.
  localparam logic [7:0] FRAMES_PER_BLOCK = 8'd192;
  localparam logic [7:0] LAST_FRAME       = FRAMES_PER_BLOCK - 8'd1;
  localparam logic [3:0] BLOCK_PREAMBLE   = 4'hF;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } sample_pair_t;

  typedef struct packed {
    logic [31:0] left_subframe;
    logic [31:0] right_subframe;
  } subframe_pair_t;

  // MAI layout: [31] even parity over [30:4], [30] status, [27:12] sample,
  // [3:0] preamble code on the first frame of a block.
  function automatic logic [31:0] build_word(logic [15:0] sample, logic cbit, logic first);
    logic [31:0] w;
    w = {1'b0, cbit, 2'b00, sample, 12'h000};
    w[31] = ^w[30:4];
    if (first) begin
      w[3:0] = BLOCK_PREAMBLE;
    end
    return w;
  endfunction

endpackage

/* rtl/core/spdif_subframe_formatter_core.sv */
// Top level: S/PDIF (IEC60958) subframe formatter, one stereo pair per transaction.
`timescale 1ns / 1ps

// Turns each stereo pair of signed 16-bit samples into two 32-bit IEC60958
// subframe words in MAI layout: sample in bits 27..12, channel-status bit in
// bit 30, even parity over bits 30..4 in bit 31, and preamble code 0xF in
// bits 3..0 on the first frame of every 192-frame block. Frame f carries bit
// f of the channel_status register while f is below STATUS_BITS (and below the
// 40 register bits), zero after that. Throughput is one pair per clock while
// subframe_stall is low; the only storage on the data path is the output
// register, and a new transaction is taken whenever that register is empty or
// is being drained in the same cycle. sample_stall is high only while a
// result sits in the output register and subframe_stall holds it there.
// Write cfg_wr_en/cfg_wr_data only while no transaction is in flight. The
// frame counter restarts at frame 0 on reset.
module spdif_subframe_formatter_core
  import spdif_fmt_pkg::*;
#(
  parameter int unsigned STATUS_BITS = STATUS_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CS_WIDTH-1:0] cfg_wr_data,
  // sample input
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_pair_t        samples,
  // subframe output
  output logic                subframe_valid,
  input  logic                subframe_stall,
  output subframe_pair_t      subframes
);

  // Only the status bits that can ever be sent are stored.
  localparam int unsigned STORE_BITS = (STATUS_BITS < CS_WIDTH) ? STATUS_BITS : CS_WIDTH;
  localparam int unsigned IDX_W      = $clog2(STORE_BITS);

  logic [STORE_BITS-1:0] channel_status;
  logic [7:0]            frame_index;
  logic [7:0]            frame_index_next;
  logic                  accept;
  logic                  status_bit;
  logic                  first_frame;
  subframe_pair_t        subframes_next;

  // Output register is free when empty or being taken this cycle.
  assign sample_stall = subframe_valid & subframe_stall;
  assign accept       = sample_valid & ~sample_stall;

  assign first_frame = (frame_index == 8'd0);
  assign status_bit  = (frame_index < 8'(STORE_BITS)) ?
                       channel_status[frame_index[IDX_W-1:0]] : 1'b0;

  assign frame_index_next = (frame_index == LAST_FRAME) ? 8'd0 : frame_index + 8'd1;

  always_comb begin
    subframes_next.left_subframe  = build_word(samples.left_sample, status_bit, first_frame);
    subframes_next.right_subframe = build_word(samples.right_sample, status_bit, first_frame);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_status <= CS_RESET[STORE_BITS-1:0];
    end else if (cfg_wr_en) begin
      channel_status <= cfg_wr_data[STORE_BITS-1:0];
    end
  end

  // Frame counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index    <= 8'd0;
      subframe_valid <= 1'b0;
    end else begin
      if (accept) begin
        frame_index    <= frame_index_next;
        subframe_valid <= 1'b1;
      end else if (!subframe_stall) begin
        subframe_valid <= 1'b0;
      end
    end
  end

  // Output payload, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      subframes <= subframes_next;
    end
  end

endmodule

/* rtl/core/spdif_fmt_checker.sv */
// Port-level checker for the S/PDIF subframe formatter, bound to the top level.
`timescale 1ns / 1ps

module spdif_fmt_checker
  import spdif_fmt_pkg::*;
(
  input logic           clk,
  input logic           rst,
  input logic           sample_stall,
  input logic           subframe_valid,
  input logic           subframe_stall,
  input subframe_pair_t subframes
);

  // Both words of a frame share status bit and preamble.
  a_pair_match: assert property (@(posedge clk) disable iff (rst)
    subframe_valid |-> (subframes.left_subframe[30] == subframes.right_subframe[30]) &&
                       (subframes.left_subframe[3:0] == subframes.right_subframe[3:0]))
    else $error("left/right status or preamble mismatch");

  // Even parity over bits 30..4 on both words.
  a_parity: assert property (@(posedge clk) disable iff (rst)
    subframe_valid |-> !(^subframes.left_subframe[31:4]) && !(^subframes.right_subframe[31:4]))
    else $error("subframe parity error");

  // Unused bits zero, preamble either absent or block start.
  a_layout: assert property (@(posedge clk) disable iff (rst)
    subframe_valid |-> (subframes.left_subframe[11:4] == 8'h00) &&
                       (subframes.left_subframe[29:28] == 2'b00) &&
                       ((subframes.left_subframe[3:0] == 4'h0) ||
                        (subframes.left_subframe[3:0] == BLOCK_PREAMBLE)))
    else $error("subframe layout error");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    subframe_valid && subframe_stall |=> subframe_valid && $stable(subframes))
    else $error("stalled subframe changed");

  // Input stalls only behind a blocked result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> subframe_valid && subframe_stall)
    else $error("input stalled while output free");

endmodule

bind spdif_subframe_formatter_core spdif_fmt_checker u_spdif_fmt_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_stall   (sample_stall),
  .subframe_valid (subframe_valid),
  .subframe_stall (subframe_stall),
  .subframes      (subframes)
);

/* bench/spdif_subframe_formatter_core_tb.sv */
// Testbench for the S/PDIF subframe formatter core: self-checking, random traffic.
`timescale 1ns / 1ps

module spdif_subframe_formatter_core_tb;
  import spdif_fmt_pkg::*;

  // Frames that carry a status bit with the default core parameter.
  localparam int unsigned STATUS_FRAMES = STATUS_BITS_DEFAULT;
  localparam int unsigned BLOCK_LEN     = 192;
  localparam int unsigned MAX_PRINTED   = 40;
  // Watchdog: several times the slowest legal run.
  localparam longint unsigned WATCHDOG_NS = 64'd20_000_000;

  // One expected transaction on the output side, tagged with its frame number
  // so a mismatch line says where in the block it happened.
  typedef struct {
    subframe_pair_t words;
    int unsigned    frame;
  } subframe_expect_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [CS_WIDTH-1:0] cfg_wr_data;
  logic                sample_valid;
  logic                sample_stall;
  sample_pair_t        samples;
  logic                subframe_valid;
  logic                subframe_stall;
  subframe_pair_t      subframes;

  // Shadow state of the formatter.
  logic [CS_WIDTH-1:0] status_shadow;
  logic [7:0]          frame_count;

  subframe_expect_t    pending_subframes[$];
  int unsigned         mismatch_count = 0;
  int unsigned         sender_quiet = 0;
  int unsigned         receiver_hold = 0;

  always #10 clk = ~clk;

  spdif_subframe_formatter_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .samples        (samples),
    .subframe_valid (subframe_valid),
    .subframe_stall (subframe_stall),
    .subframes      (subframes)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One subframe word. Bits 4..11 and 28..29 are always zero, so even parity
  // over 4..30 reduces to the XOR of the sample and the status bit. The
  // preamble nibble sits outside the parity span.
  function automatic logic [31:0] subframe_word(logic [15:0] pcm, logic cs_bit,
                                                logic frame_zero);
    logic [31:0] w;
    w        = '0;
    w[27:12] = pcm;
    w[30]    = cs_bit;
    w[31]    = (^pcm) ^ cs_bit;
    w[3:0]   = frame_zero ? BLOCK_PREAMBLE : 4'h0;
    return w;
  endfunction

  // Expected output for one accepted stereo pair; advances the frame counter.
  function automatic subframe_expect_t format_pair(sample_pair_t pair);
    subframe_expect_t e;
    logic             cs_bit;
    logic             frame_zero;
    cs_bit = 1'b0;
    if (frame_count < STATUS_FRAMES && frame_count < CS_WIDTH) begin
      cs_bit = status_shadow[frame_count];
    end
    frame_zero = (frame_count == 8'd0);
    e.words.left_subframe  = subframe_word(pair.left_sample, cs_bit, frame_zero);
    e.words.right_subframe = subframe_word(pair.right_sample, cs_bit, frame_zero);
    e.frame = frame_count;
    // Counter wraps after the last frame of the block.
    if (frame_count == BLOCK_LEN - 1) begin
      frame_count = 8'd0;
    end else begin
      frame_count = frame_count + 8'd1;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, a few long, and now and then a long
  // stretch of back-to-back transactions.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (sender_quiet > 0) begin
      sender_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      sender_quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // PCM value biased toward the range limits and other corner patterns.
  function automatic logic [15:0] random_pcm();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_pair_t random_pair();
    sample_pair_t p;
    p.left_sample  = random_pcm();
    p.right_sample = random_pcm();
    return p;
  endfunction

  function automatic logic [CS_WIDTH-1:0] random_status();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned frame,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s frame %0d: got %h want %h", $realtime, what, frame,
               got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall and the result checker
  // ---------------------------------------------------------------------------

  // Stall is driven on falling edges in runs: short free runs and short
  // stalls most of the time, occasionally a long run of either.
  initial begin
    logic stall_level;
    int unsigned r;
    subframe_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        receiver_hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_level   = 1'b0;
          receiver_hold = (r < 5) ? $urandom_range(30, 80) : $urandom_range(0, 6);
        end else begin
          stall_level   = 1'b1;
          receiver_hold = (r > 96) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        end
        subframe_stall <= stall_level;
      end
    end
  end

  // Every completed output transaction is matched against the oldest
  // expectation. Outputs are read on the rising edge, before the core's
  // registers update.
  always @(posedge clk) begin
    subframe_expect_t e;
    if (!rst && subframe_valid && !subframe_stall) begin
      if (pending_subframes.size() == 0) begin
        report_mismatch("unexpected transaction", 0, subframes.left_subframe, 'x);
      end else begin
        e = pending_subframes.pop_front();
        if (subframes.left_subframe !== e.words.left_subframe) begin
          report_mismatch("left_subframe", e.frame, subframes.left_subframe,
                          e.words.left_subframe);
        end
        if (subframes.right_subframe !== e.words.right_subframe) begin
          report_mismatch("right_subframe", e.frame, subframes.right_subframe,
                          e.words.right_subframe);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one stereo pair after a random idle gap and holds it until the core
  // takes it. Valid stays high into the next call when that call has no gap,
  // so it is never lowered and raised in the same step.
  task automatic send_pair(input sample_pair_t pair);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      samples      <= sample_pair_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    samples      <= pair;
    do @(posedge clk); while (sample_stall);
    pending_subframes.push_back(format_pair(pair));
  endtask

  // Drops valid, drains all outstanding results, then waits out the output
  // register so the core is truly idle.
  task automatic quiesce();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_subframes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Channel-status register write, only ever issued with the core idle.
  task automatic write_status(input logic [CS_WIDTH-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= random_status();
    status_shadow = value;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Sample extremes and bit patterns at the start of the first block, with the
  // reset channel status (block-start preamble on the first transaction).
  task automatic test_sample_extremes();
    logic [15:0] corners[10];
    sample_pair_t p;
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                16'h5555, 16'hAAAA, 16'h8001, 16'h00FF, 16'hFF00};
    foreach (corners[i]) begin
      p.left_sample  = corners[i];
      p.right_sample = corners[9 - i];
      send_pair(p);
    end
    foreach (corners[i]) begin
      p.left_sample  = corners[i];
      p.right_sample = corners[i];
      send_pair(p);
    end
  endtask

  // Runs well past one block with the reset status value, so the set reset bits
  // in frames 2, 32, 33 and 35 and the counter wrap are all seen.
  task automatic test_reset_status();
    send_random(260);
  endtask

  // All-ones, all-zeros and alternating status: every status frame set, clear
  // or alternating, then frames beyond the status bits must still read zero.
  task automatic test_status_extremes();
    write_status({CS_WIDTH{1'b1}});
    send_random(200);
    write_status({CS_WIDTH{1'b0}});
    send_random(200);
    write_status({(CS_WIDTH / 2){2'b01}});
    send_random(100);
    write_status({(CS_WIDTH / 2){2'b10}});
    send_random(100);
  endtask

  // Several random status values over long random streams.
  task automatic test_random_status();
    repeat (4) begin
      write_status(random_status());
      send_random($urandom_range(220, 280));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    sample_valid   = 1'b0;
    samples        = '0;
    status_shadow  = CS_RESET;
    frame_count    = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_reset_status();
    test_status_extremes();
    test_random_status();

    // Drain, then give any stray extra transaction time to show up.
    quiesce();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(WATCHDOG_NS);
    $display("timeout: %0d transactions still outstanding", pending_subframes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/spdif_fmt_pkg.sv
rtl/core/spdif_subframe_formatter_core.sv
rtl/core/spdif_fmt_checker.sv
bench/spdif_subframe_formatter_core_tb.sv
